// ===== src/nnls_pkg.sv =====
package nnls_pkg;

  localparam int unsigned COORD_BITS        = 24;
  localparam int unsigned DIFF_BITS         = COORD_BITS + 1;
  localparam int unsigned DIST_BITS         = 2 * DIFF_BITS;
  localparam int unsigned CNT_BITS          = 32;
  localparam int unsigned NUM_CNT           = 5;
  localparam int unsigned REF_DEPTH_DEFAULT = 4096;

  localparam logic [DIST_BITS-1:0] DIST_MAX      = '1;
  localparam logic [DIST_BITS-1:0] TOL_SQ_RESET  = DIST_BITS'(105);
  localparam logic [CNT_BITS-1:0]  CNT_MAX       = '1;

  localparam logic [2:0] OP_LOAD_GROUND  = 3'd0;
  localparam logic [2:0] OP_LOAD_OBJECT  = 3'd1;
  localparam logic [2:0] OP_QUERY_GROUND = 3'd2;
  localparam logic [2:0] OP_QUERY_OBJECT = 3'd3;
  localparam logic [2:0] OP_CLEAR        = 3'd4;

  localparam logic [2:0] CLS_NONE       = 3'd0;
  localparam logic [2:0] CLS_GG         = 3'd1;
  localparam logic [2:0] CLS_OG         = 3'd2;
  localparam logic [2:0] CLS_GO         = 3'd3;
  localparam logic [2:0] CLS_OO         = 3'd4;
  localparam logic [2:0] CLS_UNRESOLVED = 3'd5;

  localparam int unsigned CNT_GROUND           = 0;
  localparam int unsigned CNT_OBJECT_AS_GROUND = 1;
  localparam int unsigned CNT_GROUND_AS_OBJECT = 2;
  localparam int unsigned CNT_OBJECT           = 3;
  localparam int unsigned CNT_UNRESOLVED       = 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } item_t;

  typedef struct packed {
    logic                 status;
    logic [2:0]           match_class;
    logic [DIST_BITS-1:0] ground_distance_sq;
    logic [DIST_BITS-1:0] object_distance_sq;
    logic [CNT_BITS-1:0]  ground_hits;
    logic [CNT_BITS-1:0]  object_as_ground_hits;
    logic [CNT_BITS-1:0]  ground_as_object_hits;
    logic [CNT_BITS-1:0]  object_hits;
    logic [CNT_BITS-1:0]  unresolved_hits;
  } result_t;

  typedef struct packed {
    logic load;
    logic start;
    logic clear;
  } scan_ctl_t;

  typedef struct packed {
    logic full;
    logic busy;
  } scan_stat_t;

endpackage

// ===== src/nearest_neighbour_label_scorer.sv =====
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  item_t: opcode, coord_x, coord_y, coord_z
// result    out        result_valid/result_stall  result_t: status, class, distances, counts
// cfg       in         cfg_valid/cfg_ready    tolerance_squared, 50 bits
//
// A load, clear or ignored opcode goes from acceptance through S_PROC and S_FINISH
// to the result. A query also waits in S_WAIT until both stores finish their scans:
// each store's shared subtract-square-accumulate unit handles one coordinate per cycle,
// and both stores are scanned side by side.
// Reset is synchronous; it empties both stores, zeroes the counters and sets the
// tolerance to 105. The next item is taken while a result waits on a stall.
module nearest_neighbour_label_scorer #(
  parameter int unsigned REF_DEPTH = nnls_pkg::REF_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  nnls_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output nnls_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nnls_pkg::DIST_BITS-1:0] cfg_data
);
  import nnls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PROC   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  item_t                item_q;
  logic [DIST_BITS-1:0] tolerance;
  logic                 status_q;
  logic [CNT_BITS-1:0]  cnt [NUM_CNT];
  logic [CNT_BITS-1:0]  cnt_next [NUM_CNT];
  logic [2:0]           cls_next;
  logic                 is_query;
  logic                 out_free;
  logic                 gm;
  logic                 om;

  scan_ctl_t            g_ctl;
  scan_ctl_t            o_ctl;
  scan_stat_t           g_stat;
  scan_stat_t           o_stat;
  point_t               pt;
  logic [DIST_BITS-1:0] g_best;
  logic [DIST_BITS-1:0] o_best;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  assign pt         = '{x: item_q.coord_x, y: item_q.coord_y, z: item_q.coord_z};
  assign is_query   = (item_q.opcode == OP_QUERY_GROUND) || (item_q.opcode == OP_QUERY_OBJECT);
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    g_ctl = '0;
    o_ctl = '0;
    if (state == S_PROC) begin
      case (item_q.opcode)
        OP_LOAD_GROUND: g_ctl.load = 1'b1;
        OP_LOAD_OBJECT: o_ctl.load = 1'b1;
        OP_QUERY_GROUND, OP_QUERY_OBJECT: begin
          g_ctl.start = 1'b1;
          o_ctl.start = 1'b1;
        end
        OP_CLEAR: begin
          g_ctl.clear = 1'b1;
          o_ctl.clear = 1'b1;
        end
        default: ;
      endcase
    end
  end

  nnls_scan #(.REF_DEPTH(REF_DEPTH)) u_ground (
    .clk  (clk),
    .rst  (rst),
    .ctl  (g_ctl),
    .pt   (pt),
    .stat (g_stat),
    .best (g_best)
  );

  nnls_scan #(.REF_DEPTH(REF_DEPTH)) u_object (
    .clk  (clk),
    .rst  (rst),
    .ctl  (o_ctl),
    .pt   (pt),
    .stat (o_stat),
    .best (o_best)
  );

  always_comb begin
    gm       = (g_best < tolerance) && (g_best < o_best);
    om       = (o_best < tolerance) && (o_best < g_best);
    cnt_next = cnt;
    cls_next = CLS_NONE;
    case (item_q.opcode)
      OP_QUERY_GROUND: begin
        if (gm) begin
          cls_next             = CLS_GG;
          cnt_next[CNT_GROUND] = sat_inc(cnt[CNT_GROUND]);
        end else if (om) begin
          cls_next                       = CLS_GO;
          cnt_next[CNT_GROUND_AS_OBJECT] = sat_inc(cnt[CNT_GROUND_AS_OBJECT]);
        end else begin
          cls_next                 = CLS_UNRESOLVED;
          cnt_next[CNT_UNRESOLVED] = sat_inc(cnt[CNT_UNRESOLVED]);
        end
      end
      OP_QUERY_OBJECT: begin
        if (gm) begin
          cls_next                       = CLS_OG;
          cnt_next[CNT_OBJECT_AS_GROUND] = sat_inc(cnt[CNT_OBJECT_AS_GROUND]);
        end else if (om) begin
          cls_next             = CLS_OO;
          cnt_next[CNT_OBJECT] = sat_inc(cnt[CNT_OBJECT]);
        end else begin
          cls_next                 = CLS_UNRESOLVED;
          cnt_next[CNT_UNRESOLVED] = sat_inc(cnt[CNT_UNRESOLVED]);
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < NUM_CNT; k++) begin
          cnt_next[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_PROC;
        end
      end
      S_PROC: state_next = is_query ? S_WAIT : S_FINISH;
      S_WAIT: begin
        if (!g_stat.busy && !o_stat.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      tolerance    <= TOL_SQ_RESET;
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        tolerance <= cfg_data;
      end
      if (state == S_FINISH && out_free) begin
        result_valid <= 1'b1;
        cnt          <= cnt_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_q <= item;
    end
    if (state == S_PROC) begin
      status_q <= ((item_q.opcode == OP_LOAD_GROUND) && g_stat.full)
               || ((item_q.opcode == OP_LOAD_OBJECT) && o_stat.full);
    end
    if (state == S_FINISH && out_free) begin
      result.status                <= status_q;
      result.match_class           <= cls_next;
      result.ground_distance_sq    <= is_query ? g_best : '0;
      result.object_distance_sq    <= is_query ? o_best : '0;
      result.ground_hits           <= cnt_next[CNT_GROUND];
      result.object_as_ground_hits <= cnt_next[CNT_OBJECT_AS_GROUND];
      result.ground_as_object_hits <= cnt_next[CNT_GROUND_AS_OBJECT];
      result.object_hits           <= cnt_next[CNT_OBJECT];
      result.unresolved_hits       <= cnt_next[CNT_UNRESOLVED];
    end
  end

endmodule

// ===== src/nnls_scan.sv =====
module nnls_scan #(
  parameter int unsigned REF_DEPTH = nnls_pkg::REF_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  nnls_pkg::scan_ctl_t            ctl,
  input  nnls_pkg::point_t               pt,
  output nnls_pkg::scan_stat_t           stat,
  output logic [nnls_pkg::DIST_BITS-1:0] best
);
  import nnls_pkg::*;

  localparam int unsigned AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned FW = $clog2(REF_DEPTH + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(REF_DEPTH);

  localparam logic [1:0] PH_X = 2'd0;
  localparam logic [1:0] PH_Y = 2'd1;
  localparam logic [1:0] PH_Z = 2'd2;

  point_t mem [REF_DEPTH];
  point_t rd_data;

  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [1:0]    phase;
  logic [1:0]    p1;
  logic [1:0]    p2;
  logic [1:0]    p3;
  logic          v1;
  logic          v2;
  logic          v3;
  logic          v4;
  logic          scanning;
  logic          issuing;
  logic          full;

  logic signed [COORD_BITS-1:0] q_c;
  logic signed [COORD_BITS-1:0] r_c;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [DIFF_BITS-1:0]  diff_next;
  logic [DIST_BITS-1:0]         sq;
  logic [DIST_BITS-1:0]         acc;
  logic [DIST_BITS-1:0]         acc_next;
  logic [DIST_BITS:0]           sum;

  assign full    = (fill == FILL_MAX);
  assign issuing = scanning && (idx < fill);
  assign stat    = '{full: full, busy: scanning};

  always_ff @(posedge clk) begin
    if (ctl.load && !full) begin
      mem[fill[AW-1:0]] <= pt;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_comb begin
    case (p1)
      PH_X: begin
        q_c = pt.x;
        r_c = rd_data.x;
      end
      PH_Y: begin
        q_c = pt.y;
        r_c = rd_data.y;
      end
      default: begin
        q_c = pt.z;
        r_c = rd_data.z;
      end
    endcase
    diff_next = $signed({q_c[COORD_BITS-1], q_c}) - $signed({r_c[COORD_BITS-1], r_c});
    sum       = {1'b0, ((p3 == PH_X) ? '0 : acc)} + {1'b0, sq};
    acc_next  = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      idx      <= '0;
      phase    <= PH_X;
      scanning <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
    end else begin
      if (ctl.clear) begin
        fill <= '0;
      end else if (ctl.load && !full) begin
        fill <= fill + 1'b1;
      end
      if (ctl.start) begin
        scanning <= 1'b1;
        idx      <= '0;
        phase    <= PH_X;
      end else if (issuing) begin
        if (phase == PH_Z) begin
          phase <= PH_X;
          idx   <= idx + 1'b1;
        end else begin
          phase <= phase + 1'b1;
        end
      end else if (scanning && !v1 && !v2 && !v3 && !v4) begin
        scanning <= 1'b0;
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (p3 == PH_Z);
    end
  end

  always_ff @(posedge clk) begin
    p1   <= phase;
    p2   <= p1;
    p3   <= p2;
    diff <= diff_next;
    sq   <= diff * diff;
    if (v3) begin
      acc <= acc_next;
    end
    if (ctl.start) begin
      best <= DIST_MAX;
    end else if (v4 && (acc < best)) begin
      best <= acc;
    end
  end

endmodule
